@@ hw/rtl/lsm_pkg.sv @@
package lsm_pkg;

  // fixed arithmetic of the monitor
  localparam int unsigned POWER_CAP     = 20000;
  localparam int unsigned POWER_DIV     = 10000;
  localparam int unsigned TOTAL_DIV     = 10;
  localparam int unsigned TOTAL_MAX     = 16383;
  localparam int unsigned BLINK_MIN     = 2;
  localparam int unsigned TOGGLE_MAX    = 255;
  localparam int unsigned SUPPLY_RESET  = 11930;

  localparam int unsigned PROD_W  = 31;  // 16 bit supply times 15 bit current
  localparam int unsigned DIV_W   = 28;  // dividend width once the cap is ruled out
  localparam int unsigned QUOT_W  = 15;
  localparam int unsigned WATTS_W = 15;
  localparam int unsigned TOTAL_W = 14;
  localparam int unsigned TOG_W   = 8;

  // quotient above the cap is detected on the dividend before dividing
  localparam int unsigned CAP_PRODUCT   = (POWER_CAP + 1) * POWER_DIV;
  localparam int unsigned TOTAL_CAP_SUM = (TOTAL_MAX + 1) * TOTAL_DIV;

  // division by a constant as a multiply by the rounded-up reciprocal and a shift,
  // exact for every dividend below 2**DIV_W
  localparam int unsigned RECIP_W   = 29;
  localparam int unsigned MULT_W    = DIV_W + RECIP_W;
  localparam int unsigned PWR_SHIFT = 42;
  localparam int unsigned TOT_SHIFT = 32;
  localparam logic [RECIP_W-1:0] PWR_RECIP = 29'd439804652;  // 2**42 / 10000, rounded up
  localparam logic [RECIP_W-1:0] TOT_RECIP = 29'd429496730;  // 2**32 / 10, rounded up

  typedef enum logic [1:0] {
    ACT_SAMPLE  = 2'd0,
    ACT_CLOSE   = 2'd1,
    ACT_REBCAST = 2'd2
  } action_t;

  typedef enum logic [0:0] {
    REG_ENABLE = 1'b0,
    REG_SUPPLY = 1'b1
  } cfg_reg_t;

  localparam logic [0:0] KIND_CHANNEL = 1'b0;
  localparam logic [0:0] KIND_TOTAL   = 1'b1;

  localparam logic [1:0] RPT_OFF   = 2'd0;
  localparam logic [1:0] RPT_ON    = 2'd1;
  localparam logic [1:0] RPT_BLINK = 2'd2;

  localparam logic [2:0] FAULT_GOOD      = 3'd0;
  localparam logic [2:0] FAULT_OPEN_LOAD = 3'd7;

  typedef struct packed {
    logic [1:0]         action;
    logic [2:0]         channel;
    logic signed [15:0] current_ma;
    logic               switch_on;
    logic [2:0]         driver_fault;
    logic [15:0]        open_thr_ma;
  } in_item_t;

  typedef struct packed {
    logic [0:0]  kind;
    logic [3:0]  chan_num;
    logic [1:0]  report_state;
    logic [2:0]  fault_status;
    logic [14:0] watts_cw;
    logic [13:0] total_dw;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic               start;
    logic [DIV_W-1:0]   dividend;
    logic [RECIP_W-1:0] recip;
    logic               sel_total;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_PSTART,
    S_PDIV,
    S_UPD,
    S_SREP,
    S_CLOSE,
    S_TSTART,
    S_TDIV,
    S_TOUT,
    S_REBC
  } state_t;

endpackage

@@ hw/rtl/lsm_in_if.sv @@
interface lsm_in_if import lsm_pkg::*;;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/lsm_out_if.sv @@
interface lsm_out_if import lsm_pkg::*;;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/lsm_cfg_if.sv @@
interface lsm_cfg_if import lsm_pkg::*;;
  logic        valid;
  logic        ready;
  cfg_reg_t    index;
  logic [15:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

@@ hw/rtl/load_switch_channel_monitor.sv @@
// load-switch channel monitor
// channels: cfg (register writes, always ready), items (sample, window close,
// fault rebroadcast transactions) and results (channel and total reports,
// last set on the final report of each input transaction)
// items is ready only in the idle state; one transaction is worked at a time
// a sample steps through a multiply, a cap check, a reciprocal multiply by
// 1/10000 in the shared unit, then the state update and, when it reports, a
// report state that loads its report into the output register; a capped
// power skips the reciprocal step
// a window close goes through its accepting state, one step per channel
// report, then the tenth of the total in the shared unit unless capped, and its report
// a rebroadcast scans the channels in order, reporting each one faulted at acceptance
// results sit in an output register; while the receiver stalls the sequencer
// holds at its next report, and after the last report the block is ready
// for a new transaction even if that report has not been taken yet
// reset clears all channel state, disables the block and loads the
// default supply voltage; no clearing pass is needed
module load_switch_channel_monitor import lsm_pkg::*; #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic      clk,
  input  logic      rst,
  lsm_cfg_if.sink   cfg,
  lsm_in_if.sink    items,
  lsm_out_if.source results
);

  localparam int IW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int TOT_W = $clog2(NUM_CHANNELS * POWER_CAP + 1);

  // configuration registers
  logic        enable;
  logic [15:0] supply_mv;

  // per-channel state
  logic               prev_on       [NUM_CHANNELS];
  logic [TOG_W-1:0]   toggle_count  [NUM_CHANNELS];
  logic [WATTS_W-1:0] peak_power    [NUM_CHANNELS];
  logic [WATTS_W-1:0] channel_power [NUM_CHANNELS];
  logic [2:0]         fault_state   [NUM_CHANNELS];

  // sequencer registers
  state_t             st, st_next;
  logic [IW-1:0]      idx, idx_next;
  logic [PROD_W-1:0]  prod, prod_next;
  logic [QUOT_W-1:0]  res, res_next;
  logic [TOT_W-1:0]   total, total_next;
  logic [NUM_CHANNELS-1:0] pending, pending_next;
  logic [14:0]        ma, ma_next;
  logic               on, on_next;
  logic [2:0]         drv, drv_next;
  logic [15:0]        thr, thr_next;

  // output register
  logic      out_valid;
  out_item_t out_data;
  logic      load;
  out_item_t load_item;
  logic      slot_free;

  // shared reciprocal divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  // read view of the addressed channel
  logic               rd_blink;
  logic [WATTS_W-1:0] rd_view;
  out_item_t          rep;
  logic [NUM_CHANNELS-1:0] fault_mask;
  logic [NUM_CHANNELS-1:0] pend_rest;

  // sample update values
  logic [2:0]       ns;
  logic [TOG_W-1:0] tog_upd;
  logic             clear_win;

  lsm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // configuration writes, to be issued only while idle; the block itself does not enforce it
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable    <= 1'b0;
      supply_mv <= 16'(SUPPLY_RESET);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_ENABLE: enable    <= cfg.wdata[0];
        REG_SUPPLY: supply_mv <= cfg.wdata;
        default: ;
      endcase
    end
  end

  // report of the channel at idx, built from stored state
  always_comb begin
    rd_blink = toggle_count[idx] >= TOG_W'(BLINK_MIN);
    rd_view  = rd_blink ? peak_power[idx] : channel_power[idx];
    rep                = '0;
    rep.kind           = KIND_CHANNEL;
    rep.chan_num       = 4'(idx) + 4'd1;
    rep.report_state   = rd_blink ? RPT_BLINK : (prev_on[idx] ? RPT_ON : RPT_OFF);
    rep.fault_status   = fault_state[idx];
    rep.watts_cw       = rd_view;
    rep.total_dw       = '0;
    rep.last           = 1'b0;
  end

  always_comb begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      fault_mask[c] = fault_state[c] != FAULT_GOOD;
    end
    pend_rest      = pending;
    pend_rest[idx] = 1'b0;
  end

  // new fault code and toggle count for the sampled channel
  always_comb begin
    if (drv != FAULT_GOOD) begin
      ns = drv;
    end else if (on && ({1'b0, ma} < thr)) begin
      ns = FAULT_OPEN_LOAD;
    end else begin
      ns = FAULT_GOOD;
    end
    if ((on != prev_on[idx]) && (toggle_count[idx] != TOG_W'(TOGGLE_MAX))) begin
      tog_upd = toggle_count[idx] + TOG_W'(1);
    end else begin
      tog_upd = toggle_count[idx];
    end
  end

  assign slot_free   = !out_valid || results.ready;
  assign items.ready = (st == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    idx     <= idx_next;
    prod    <= prod_next;
    res     <= res_next;
    total   <= total_next;
    pending <= pending_next;
    ma      <= ma_next;
    on      <= on_next;
    drv     <= drv_next;
    thr     <= thr_next;
  end

  // sequencer
  always_comb begin
    st_next      = st;
    idx_next     = idx;
    prod_next    = prod;
    res_next     = res;
    total_next   = total;
    pending_next = pending;
    ma_next      = ma;
    on_next      = on;
    drv_next     = drv;
    thr_next     = thr;
    load         = 1'b0;
    load_item    = rep;
    div_req      = '0;
    clear_win    = 1'b0;

    unique case (st)
      S_IDLE: begin
        if (items.valid && enable) begin
          unique case (items.data.action)
            ACT_SAMPLE: begin
              if (32'(items.data.channel) < NUM_CHANNELS) begin
                idx_next = IW'(items.data.channel);
                ma_next  = items.data.current_ma[15] ? 15'd0 : items.data.current_ma[14:0];
                on_next  = items.data.switch_on;
                drv_next = items.data.driver_fault;
                thr_next = items.data.open_thr_ma;
                st_next  = S_MUL;
              end
            end
            ACT_CLOSE: begin
              idx_next   = '0;
              total_next = '0;
              st_next    = S_CLOSE;
            end
            ACT_REBCAST: begin
              idx_next     = '0;
              pending_next = fault_mask;
              st_next      = S_REBC;
            end
            default: ;
          endcase
        end
      end
      S_MUL: begin
        prod_next = PROD_W'(supply_mv) * PROD_W'(ma);
        st_next   = S_PSTART;
      end
      S_PSTART: begin
        if (prod >= PROD_W'(CAP_PRODUCT)) begin
          res_next = QUOT_W'(POWER_CAP);
          st_next  = S_UPD;
        end else begin
          div_req.start     = 1'b1;
          div_req.dividend  = DIV_W'(prod);
          div_req.recip     = PWR_RECIP;
          div_req.sel_total = 1'b0;
          st_next           = S_PDIV;
        end
      end
      S_PDIV: begin
        if (div_rsp.done) begin
          res_next = div_rsp.quotient;
          st_next  = S_UPD;
        end
      end
      S_UPD: begin
        // a report goes out only when the fault code changes
        st_next = (ns != fault_state[idx]) ? S_SREP : S_IDLE;
      end
      S_SREP: begin
        if (slot_free) begin
          load           = 1'b1;
          load_item.last = 1'b1;
          st_next        = S_IDLE;
        end
      end
      S_CLOSE: begin
        if (slot_free) begin
          load       = 1'b1;
          clear_win  = 1'b1;
          total_next = total + TOT_W'(rd_view);
          if (idx == IW'(NUM_CHANNELS - 1)) begin
            st_next = S_TSTART;
          end else begin
            idx_next = idx + IW'(1);
          end
        end
      end
      S_TSTART: begin
        if (32'(total) >= TOTAL_CAP_SUM) begin
          res_next = QUOT_W'(TOTAL_MAX);
          st_next  = S_TOUT;
        end else begin
          div_req.start     = 1'b1;
          div_req.dividend  = DIV_W'(total);
          div_req.recip     = TOT_RECIP;
          div_req.sel_total = 1'b1;
          st_next           = S_TDIV;
        end
      end
      S_TDIV: begin
        if (div_rsp.done) begin
          res_next = div_rsp.quotient;
          st_next  = S_TOUT;
        end
      end
      S_TOUT: begin
        if (slot_free) begin
          load                     = 1'b1;
          load_item                = '0;
          load_item.kind           = KIND_TOTAL;
          load_item.total_dw       = res[TOTAL_W-1:0];
          load_item.last           = 1'b1;
          st_next                  = S_IDLE;
        end
      end
      S_REBC: begin
        if (pending == '0) begin
          st_next = S_IDLE;
        end else if (!pending[idx]) begin
          idx_next = idx + IW'(1);
        end else if (slot_free) begin
          load           = 1'b1;
          load_item.last = (pend_rest == '0);
          pending_next   = pend_rest;
          idx_next       = idx + IW'(1);
        end
      end
      default: st_next = S_IDLE;
    endcase
  end

  // channel state writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        prev_on[c]       <= 1'b0;
        toggle_count[c]  <= '0;
        peak_power[c]    <= '0;
        channel_power[c] <= '0;
        fault_state[c]   <= FAULT_GOOD;
      end
    end else if (st == S_UPD) begin
      channel_power[idx] <= res;
      toggle_count[idx]  <= tog_upd;
      prev_on[idx]       <= on;
      fault_state[idx]   <= ns;
      if (res > peak_power[idx]) begin
        peak_power[idx] <= res;
      end
    end else if (clear_win) begin
      // window cleared channel by channel as its report is loaded into the output register
      toggle_count[idx] <= '0;
      peak_power[idx]   <= '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_item;
    end
  end

  assign results.valid = out_valid;
  assign results.data  = out_data;

  // the divider only finishes while the sequencer waits for it
  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (st == S_PDIV || st == S_TDIV))
    else $error("divider finished outside a wait state");

  // a total report is only loaded at the end of a window close
  a_total_from_close: assert property (@(posedge clk) disable iff (rst)
    (load && load_item.kind == KIND_TOTAL) |-> (st == S_TOUT))
    else $error("total report loaded outside window close");

  // the scan pointer stays inside the channel range
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (st == S_CLOSE || st == S_REBC) |-> (32'(idx) < NUM_CHANNELS))
    else $error("scan index beyond channel count");

  // rebroadcast never adds pending channels
  a_pending_shrinks: assert property (@(posedge clk) disable iff (rst)
    (st == S_REBC) |=> ((pending & ~$past(pending)) == '0))
    else $error("rebroadcast pending set grew");

endmodule

@@ hw/rtl/lsm_div.sv @@
module lsm_div import lsm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              done;
  logic              sel_total;
  logic [MULT_W-1:0] prod;

  // one reciprocal multiply per request, the quotient is a slice of the product
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req.start;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      prod      <= MULT_W'(req.dividend) * MULT_W'(req.recip);
      sel_total <= req.sel_total;
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = sel_total ? prod[TOT_SHIFT +: QUOT_W] : prod[PWR_SHIFT +: QUOT_W];

endmodule

@@ verif/testbench.sv @@
module testbench import lsm_pkg::*;;

  localparam int NCH            = 8;
  localparam int QUIET_CYCLES   = 60;    // longest transaction is a close
  localparam int WATCHDOG_LIMIT = 3000;  // cycles without any transaction
  localparam int IDLE_PERCENT   = 38;
  localparam int BURST_SAMPLES  = 257;   // enough toggles to saturate the counter
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // expected reports of the monitor, kept from its own copy of the channel state
  class lsm_scoreboard;
    bit          enabled;
    logic [15:0] supply;
    bit          prev_on [NCH];
    logic [7:0]  toggles [NCH];
    logic [14:0] peak    [NCH];
    logic [14:0] power   [NCH];
    logic [2:0]  fault   [NCH];
    out_item_t   expected_reports [$];
    int          errors;

    function new();
      enabled = 1'b0;
      supply  = 16'(SUPPLY_RESET);
      errors  = 0;
      for (int c = 0; c < NCH; c++) begin
        prev_on[c] = 1'b0;
        toggles[c] = '0;
        peak[c]    = '0;
        power[c]   = '0;
        fault[c]   = FAULT_GOOD;
      end
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    function void set_register(cfg_reg_t idx, logic [15:0] value);
      if (idx == REG_ENABLE) begin
        enabled = value[0];
      end else begin
        supply = value;
      end
    endfunction

    // what a report of channel c shows right now
    function out_item_t channel_report(int c, bit fin);
      out_item_t r;
      r = '0;
      r.kind           = KIND_CHANNEL;
      r.chan_num       = 4'(c + 1);
      if (toggles[c] >= BLINK_MIN) begin
        r.report_state = RPT_BLINK;
        r.watts_cw     = peak[c];
      end else begin
        r.report_state = prev_on[c] ? RPT_ON : RPT_OFF;
        r.watts_cw     = power[c];
      end
      r.fault_status = fault[c];
      r.last         = fin;
      return r;
    endfunction

    function void note_item(in_item_t it);
      logic [15:0] ma;
      logic [31:0] product;
      logic [31:0] watts;
      logic [2:0]  next_fault;
      int          c;
      int          sum;
      int          n_queued;
      out_item_t   r;
      if (!enabled) return;
      if (it.action == ACT_SAMPLE) begin
        c       = int'(it.channel);
        ma      = it.current_ma[15] ? 16'd0 : it.current_ma;
        product = 32'(supply) * 32'(ma);
        watts   = product / POWER_DIV;
        power[c] = (watts > POWER_CAP) ? 15'(POWER_CAP) : 15'(watts);
        if (it.switch_on != prev_on[c] && toggles[c] < TOGGLE_MAX) toggles[c]++;
        prev_on[c] = it.switch_on;
        if (power[c] > peak[c]) peak[c] = power[c];
        if (it.driver_fault != FAULT_GOOD) begin
          next_fault = it.driver_fault;
        end else if (it.switch_on && ma < it.open_thr_ma) begin
          next_fault = FAULT_OPEN_LOAD;
        end else begin
          next_fault = FAULT_GOOD;
        end
        if (next_fault != fault[c]) begin
          fault[c] = next_fault;
          expected_reports.push_back(channel_report(c, 1'b1));
        end
      end else if (it.action == ACT_CLOSE) begin
        sum = 0;
        for (int k = 0; k < NCH; k++) begin
          r = channel_report(k, 1'b0);
          sum += int'(r.watts_cw);
          expected_reports.push_back(r);
        end
        sum = sum / TOTAL_DIV;
        r = '0;
        r.kind     = KIND_TOTAL;
        r.total_dw = (sum > TOTAL_MAX) ? 14'(TOTAL_MAX) : 14'(sum);
        r.last     = 1'b1;
        expected_reports.push_back(r);
        // window cleared, on flags kept
        for (int k = 0; k < NCH; k++) begin
          toggles[k] = '0;
          peak[k]    = '0;
        end
      end else if (it.action == ACT_REBCAST) begin
        n_queued = expected_reports.size();
        for (int k = 0; k < NCH; k++) begin
          if (fault[k] != FAULT_GOOD) expected_reports.push_back(channel_report(k, 1'b0));
        end
        if (expected_reports.size() > n_queued) begin
          expected_reports[expected_reports.size() - 1].last = 1'b1;
        end
      end
    endfunction

    task log_mismatch(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_report(out_item_t got);
      out_item_t want;
      if (expected_reports.size() == 0) begin
        log_mismatch($sformatf("report %h with nothing expected", got));
        return;
      end
      want = expected_reports.pop_front();
      if (got.kind !== want.kind)
        log_mismatch($sformatf("kind %h, expected %h", got.kind, want.kind));
      if (got.chan_num !== want.chan_num)
        log_mismatch($sformatf("chan_num %0d, expected %0d",
                               got.chan_num, want.chan_num));
      if (got.report_state !== want.report_state)
        log_mismatch($sformatf("channel %0d report_state %0d, expected %0d",
                               want.chan_num, got.report_state, want.report_state));
      if (got.fault_status !== want.fault_status)
        log_mismatch($sformatf("channel %0d fault_status %0d, expected %0d",
                               want.chan_num, got.fault_status, want.fault_status));
      if (got.watts_cw !== want.watts_cw)
        log_mismatch($sformatf("channel %0d watts_cw %0d, expected %0d",
                               want.chan_num, got.watts_cw, want.watts_cw));
      if (got.total_dw !== want.total_dw)
        log_mismatch($sformatf("total_dw %0d, expected %0d", got.total_dw, want.total_dw));
      if (got.last !== want.last)
        log_mismatch($sformatf("channel %0d last %b, expected %b",
                               want.chan_num, got.last, want.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   steady = 1'b0;   // both sides without idling
  int   stall_cycles = 0;

  lsm_scoreboard sb = new();

  lsm_cfg_if cfg_bus ();
  lsm_in_if  item_bus ();
  lsm_out_if report_bus ();

  load_switch_channel_monitor #(
    .NUM_CHANNELS(NCH)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_bus),
    .items   (item_bus),
    .results (report_bus)
  );

  always #6 clk = ~clk;

  // receiver side: random back-pressure unless in the steady stretch
  always @(posedge clk) begin
    report_bus.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
  end

  // observe every transaction on the three channels
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_bus.valid && cfg_bus.ready) sb.set_register(cfg_bus.index, cfg_bus.wdata);
      if (item_bus.valid && item_bus.ready) sb.note_item(item_bus.data);
      if (report_bus.valid && report_bus.ready) sb.check_report(report_bus.data);
    end
  end

  // watchdog: ends a run that stops making progress
  always @(posedge clk) begin
    if (rst || (cfg_bus.valid && cfg_bus.ready) || (item_bus.valid && item_bus.ready) ||
        (report_bus.valid && report_bus.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic in_item_t sample_of(logic [2:0] ch, logic [15:0] cur, bit on,
                                         logic [2:0] drv, logic [15:0] thr);
    in_item_t it;
    it.action       = ACT_SAMPLE;
    it.channel      = ch;
    it.current_ma   = cur;
    it.switch_on    = on;
    it.driver_fault = drv;
    it.open_thr_ma  = thr;
    return it;
  endfunction

  // close, rebroadcast or unused code, with random filler in the other fields
  function automatic in_item_t control_of(logic [1:0] act);
    in_item_t it;
    it = sample_of(3'($urandom), 16'($urandom), 1'($urandom), 3'($urandom), 16'($urandom));
    it.action = act;
    return it;
  endfunction

  // sample weighted towards the interesting corners: negatives, the cap, the threshold
  function automatic in_item_t random_sample();
    logic [15:0] cur;
    logic [15:0] thr;
    logic [2:0]  drv;
    case ($urandom_range(0, 5))
      0: cur = 16'($urandom);
      1: cur = 16'h8000 | 16'($urandom);
      2: cur = 16'($urandom_range(0, 300));
      3: begin
        case ($urandom_range(0, 3))
          0: cur = 16'h7FFF;
          1: cur = 16'h8000;
          2: cur = 16'h0000;
          default: cur = 16'hFFFF;
        endcase
      end
      default: cur = 16'($urandom_range(0, 20000));
    endcase
    case ($urandom_range(0, 5))
      0: thr = 16'($urandom);
      1: thr = cur + 16'($urandom_range(0, 2)) - 16'd1;  // right at the current
      2: thr = 16'd0;
      3: thr = 16'hFFFF;
      default: thr = 16'($urandom_range(0, 3000));
    endcase
    drv = ($urandom_range(0, 99) < 75) ? 3'd0 : 3'($urandom_range(1, 7));
    return sample_of(3'($urandom_range(0, NCH - 1)), cur, $urandom_range(0, 99) < 60, drv, thr);
  endfunction

  // present one transaction and hold it until accepted
  task automatic send_item(in_item_t it);
    while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      item_bus.valid <= 1'b0;
      @(posedge clk);
    end
    item_bus.valid <= 1'b1;
    item_bus.data  <= it;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
  endtask

  // wait for every expected report, then let a transaction with no report finish
  task automatic settle();
    item_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // supply first, then enable; the enable word carries random upper bits
  task automatic configure(bit en, logic [15:0] mv);
    logic [15:0] en_word;
    en_word = (16'($urandom) & 16'hFFFE) | 16'(en);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= REG_SUPPLY;
    cfg_bus.wdata <= mv;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.index <= REG_ENABLE;
    cfg_bus.wdata <= en_word;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // windows of samples mostly ending in a close, with rebroadcasts and unused codes between
  task automatic run_windows(int n_items);
    int sent;
    int len;
    int pick;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, 12);
      for (int k = 0; k < len && sent < n_items; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          send_item(control_of(ACT_UNUSED));
        end else if (pick < 12) begin
          send_item(control_of(ACT_REBCAST));
          sent++;
        end else begin
          send_item(random_sample());
          sent++;
        end
      end
      if ($urandom_range(0, 9) != 0) begin
        send_item(control_of(ACT_CLOSE));
        sent++;
      end
    end
  endtask

  initial begin
    logic [2:0] burst_ch;
    in_item_t   burst_src;
    cfg_bus.valid    <= 1'b0;
    cfg_bus.index    <= REG_ENABLE;
    cfg_bus.wdata    <= '0;
    item_bus.valid   <= 1'b0;
    item_bus.data    <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // disabled after reset: everything ignored
    send_item(sample_of(3'd2, 16'd100, 1'b1, 3'd5, 16'd0));
    send_item(control_of(ACT_CLOSE));
    send_item(control_of(ACT_REBCAST));
    settle();
    configure(1'b1, 16'(SUPPLY_RESET));

    // directed part at the default supply
    send_item(control_of(ACT_REBCAST));                           // nothing faulted yet
    send_item(sample_of(3'd0, 16'h7FFF, 1'b1, 3'd0, 16'd0));       // power capped, no fault
    send_item(sample_of(3'd0, 16'h8000, 1'b1, 3'd0, 16'd100));     // negative current, open load
    send_item(sample_of(3'd1, 16'd1000, 1'b0, 3'd6, 16'd0));       // driver fault passed through
    send_item(sample_of(3'd2, 16'd500, 1'b1, 3'd7, 16'd0));        // driver status seven
    send_item(sample_of(3'd3, 16'd200, 1'b1, 3'd0, 16'd200));      // current equal to threshold
    send_item(sample_of(3'd3, 16'd199, 1'b1, 3'd0, 16'd200));      // just below: open load
    send_item(sample_of(3'd3, 16'd5000, 1'b0, 3'd0, 16'hFFFF));    // switched off, second toggle
    send_item(sample_of(3'd4, 16'h7FFF, 1'b1, 3'd0, 16'hFFFF));    // largest threshold
    send_item(sample_of(3'd7, 16'hFFFF, 1'b1, 3'd1, 16'h8000));    // top channel
    send_item(control_of(ACT_UNUSED));
    send_item(control_of(ACT_REBCAST));
    send_item(control_of(ACT_CLOSE));
    send_item(sample_of(3'd5, 16'd8383, 1'b1, 3'd0, 16'd0));
    send_item(sample_of(3'd6, 16'd16764, 1'b1, 3'd2, 16'd0));      // just under the cap
    send_item(sample_of(3'd6, 16'd16765, 1'b1, 3'd0, 16'd0));      // exactly at the cap
    send_item(sample_of(3'd5, 16'd16766, 1'b0, 3'd3, 16'd0));      // just above the cap
    send_item(sample_of(3'd7, 16'd0, 1'b0, 3'd0, 16'd0));          // fault cleared
    send_item(control_of(ACT_REBCAST));
    send_item(control_of(ACT_CLOSE));
    settle();

    // largest supply; toggle counter driven into saturation without idling
    configure(1'b1, 16'hFFFF);
    steady = 1'b1;
    burst_ch = 3'($urandom_range(0, NCH - 1));
    for (int i = 0; i < BURST_SAMPLES; i++) begin
      burst_src = random_sample();
      send_item(sample_of(burst_ch, burst_src.current_ma, i[0],
                          burst_src.driver_fault, burst_src.open_thr_ma));
    end
    send_item(control_of(ACT_CLOSE));
    steady = 1'b0;
    run_windows(60);
    settle();

    // zero supply: every power reads zero
    configure(1'b1, 16'd0);
    run_windows(40);
    settle();

    // disabled again with a random supply
    configure(1'b0, 16'($urandom));
    for (int i = 0; i < 4; i++) send_item(random_sample());
    send_item(control_of(ACT_CLOSE));
    settle();

    configure(1'b1, 16'($urandom));
    run_windows(70);
    settle();

    configure(1'b1, 16'(SUPPLY_RESET));
    run_windows(10);
    settle();

    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/lsm_pkg.sv
hw/rtl/lsm_in_if.sv
hw/rtl/lsm_out_if.sv
hw/rtl/lsm_cfg_if.sv
hw/rtl/lsm_div.sv
hw/rtl/load_switch_channel_monitor.sv
verif/testbench.sv
